// ===== rtl/floppy_nibble_shift_latch_unit_defines.svh =====
// Assertion macros shared by the floppy nibble shift/latch RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef FLOPPY_NIBBLE_SHIFT_LATCH_UNIT_DEFINES_SVH
`define FLOPPY_NIBBLE_SHIFT_LATCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked on every rising edge outside reset.
`define FNSL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fnsl implication check failed");
// Condition that must never be true outside reset.
`define FNSL_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("fnsl forbidden condition seen");
`else
`define FNSL_ASSERT_IMPL(label, ante, cons)
`define FNSL_ASSERT_NEVER(label, expr)
`endif

`endif

// ===== rtl/fnsl_pkg.sv =====
// Package for the floppy nibble shift/latch unit: constants, codes, types.
// No dependencies; used by fnsl_mod_unit and the top level.
`timescale 1ns / 1ps

package fnsl_pkg;

  localparam int CYCLES_PER_BIT = 4;
  localparam int LOWEST_TRACK   = 0;
  localparam int HIGHEST_TRACK  = 34;
  localparam int HOLD_CELLS     = 2;

  localparam int REM_W   = (CYCLES_PER_BIT > 1) ? $clog2(CYCLES_PER_BIT) : 1;
  localparam int TRACK_W = 6;
  localparam int HOLD_W  = 2;
  localparam int POS_W   = 16;

  // Dividend is position or position + 1, one bit wider than a position.
  localparam int DIV_STEPS = POS_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [7:0]  NIBBLE_READY = 8'h80;
  localparam logic [14:0] DUE_MAX      = 15'h7FFF;

  // Operation codes
  localparam logic [2:0] OP_CYCLES    = 3'd0;
  localparam logic [2:0] OP_BIT_CELL  = 3'd1;
  localparam logic [2:0] OP_LATCH_RD  = 3'd2;
  localparam logic [2:0] OP_LATCH_WR  = 3'd3;
  localparam logic [2:0] OP_TRACK_CHG = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_MOTOR_ON      = 2'd0;
  localparam logic [1:0] CFG_WRITE_MODE    = 2'd1;
  localparam logic [1:0] CFG_DISK_PRESENT  = 2'd2;
  localparam logic [1:0] CFG_WRITE_PROTECT = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

// ===== rtl/fnsl_mod_unit.sv =====
// Iterative restoring modulo unit: one remainder bit per cycle.
// Depends on fnsl_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "floppy_nibble_shift_latch_unit_defines.svh"

module fnsl_mod_unit
  import fnsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [POS_W:0]       dividend,
  input  logic [POS_W-1:0]     divisor,
  output mod_stat_t            stat,
  output logic [POS_W-1:0]     remainder
);

  logic [POS_W-1:0]     rem_r, rem_nxt;
  logic [POS_W:0]       dq_r;
  logic [POS_W-1:0]     div_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [POS_W:0]       trial;
  logic [POS_W:0]       trial_diff;
  logic                 trial_ge;

  // Bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial      = {rem_r, dq_r[POS_W]};
    trial_ge   = (trial >= {1'b0, div_r});
    trial_diff = trial - {1'b0, div_r};
    rem_nxt    = trial_ge ? trial_diff[POS_W-1:0] : trial[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start && !busy_r) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      dq_r   <= dividend;
      div_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[POS_W-1:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

  `FNSL_ASSERT_IMPL(a_rem_below_div, done_r, rem_r < div_r)
  `FNSL_ASSERT_NEVER(a_start_while_busy, start && busy_r)
  `FNSL_ASSERT_IMPL(a_cnt_bound, busy_r, cnt_r < DIV_CNT_W'(DIV_STEPS))

endmodule

// ===== rtl/floppy_nibble_shift_latch_unit.sv =====
// Floppy bit-cell shift/latch engine: top level, sequencer and state.
// Depends on fnsl_pkg, fnsl_mod_unit and the assertion macro header.
`timescale 1ns / 1ps
`include "floppy_nibble_shift_latch_unit_defines.svh"

// Usage:
//   Input channel in_*: one request per operation (cycles, bit cell, latch
//   read, latch write, track change). Accepted when in_valid is high and
//   in_stall is low. Output channel out_*: exactly one result per request,
//   taken when out_valid is high and out_stall is low.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (motor,
//   write mode, disk present, write protect); write only while idle.
// Sequencing:
//   The sequencer takes one request at a time. It accepts a request in
//   S_IDLE, registers the result from S_EXEC once the result register is
//   free, and returns to S_IDLE before it accepts the next request. A bit
//   cell whose next position would pass the track length, and a track
//   change whose position needs reducing, go through S_DIV and run the
//   shared modulo unit over all dividend bits before writing the result.
// Reset:
//   Synchronous, active low; all engine state and configuration clear to 0.
// Stall:
//   A request waits in the working registers until the result register is
//   free; a stalled result holds its value.

module floppy_nibble_shift_latch_unit
  import fnsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [15:0]        in_cycles,
  input  logic               in_disk_bit,
  input  logic [15:0]        in_track_bit_count,
  input  logic signed [7:0]  in_requested_track,
  input  logic [7:0]         in_latch_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        out_bits_due,
  output logic [15:0]        out_bit_position,
  output logic               out_write_enable,
  output logic               out_write_bit,
  output logic [7:0]         out_read_value,
  output logic [31:0]        out_nibbles_read,
  output logic [31:0]        out_nibbles_written,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  localparam logic signed [8:0] LOW_S  = 9'(LOWEST_TRACK);
  localparam logic signed [8:0] HIGH_S = 9'(HIGHEST_TRACK);

  state_t state_r, state_nxt;

  // Configuration
  logic motor_r, wmode_r, disk_r, wprot_r;
  logic motor_nxt, wmode_nxt, disk_nxt, wprot_nxt;

  // Engine state
  logic [POS_W-1:0]   position_r, position_nxt;
  logic [REM_W-1:0]   crem_r, crem_nxt;
  logic [7:0]         vis_r, vis_nxt;
  logic [7:0]         asm_r, asm_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic [7:0]         olatch_r, olatch_nxt;
  logic [TRACK_W-1:0] track_r, track_nxt;
  logic [31:0]        rd_cnt_r, rd_cnt_nxt;
  logic [31:0]        wr_cnt_r, wr_cnt_nxt;

  // Captured request
  logic [2:0]         req_op_r;
  logic [15:0]        req_cycles_r;
  logic               req_bit_r;
  logic [15:0]        req_tbc_r;
  logic signed [7:0]  req_track_r;
  logic [7:0]         req_latch_r;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [14:0]        o_due_r, o_due_nxt;
  logic [15:0]        o_pos_r, o_pos_nxt;
  logic               o_wen_r, o_wen_nxt;
  logic               o_wbit_r, o_wbit_nxt;
  logic [7:0]         o_read_r, o_read_nxt;
  logic [31:0]        o_nr_r, o_nr_nxt;
  logic [31:0]        o_nw_r, o_nw_nxt;

  // Modulo unit hookup
  logic               mod_start;
  logic [POS_W:0]     mod_dividend;
  mod_stat_t          mod_stat;
  logic [POS_W-1:0]   mod_rem;

  // Combinational helpers
  logic               out_free;
  logic [16:0]        acc;
  logic [16:0]        due_full;
  logic [14:0]        due_sat;
  logic [REM_W-1:0]   crem_acc;
  logic [7:0]         asm_sh;
  logic [HOLD_W-1:0]  hold_dec;
  logic [7:0]         vis_rd;
  logic [7:0]         asm_rd;
  logic [HOLD_W-1:0]  hold_rd;
  logic               cell_ok;
  logic [POS_W:0]     pos_inc;
  logic signed [8:0]  trk_s;
  logic [TRACK_W-1:0] trk_clamp;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    acc      = 17'(req_cycles_r) + 17'(crem_r);
    due_full = 17'(acc / CYCLES_PER_BIT);
    crem_acc = REM_W'(acc % CYCLES_PER_BIT);
    due_sat  = (due_full > 17'(DUE_MAX)) ? DUE_MAX : due_full[14:0];
  end

  // Read path: shift in, then let the visible latch follow unless holding.
  always_comb begin
    asm_sh = {asm_r[6:0], req_bit_r};
    if (hold_r == '0) begin
      hold_dec = '0;
    end else if (asm_sh == 8'h00) begin
      hold_dec = hold_r;
    end else begin
      hold_dec = hold_r - 1'b1;
    end
    vis_rd  = vis_r;
    asm_rd  = asm_sh;
    hold_rd = hold_dec;
    if (hold_dec == '0) begin
      vis_rd = asm_sh;
      if ((asm_sh & NIBBLE_READY) != 8'h00) begin
        hold_rd = HOLD_W'(HOLD_CELLS);
        asm_rd  = 8'h00;
      end
    end
  end

  always_comb begin
    cell_ok = disk_r && (req_tbc_r != 16'h0000);
    pos_inc = {1'b0, position_r} + 17'd1;
    trk_s   = 9'(req_track_r);
    if (trk_s < LOW_S) begin
      trk_clamp = TRACK_W'(LOWEST_TRACK);
    end else if (trk_s > HIGH_S) begin
      trk_clamp = TRACK_W'(HIGHEST_TRACK);
    end else begin
      trk_clamp = trk_s[TRACK_W-1:0];
    end
  end

  // Kick the modulo unit only when the fast compare cannot settle it.
  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = pos_inc;
    if (state_r == S_EXEC && out_free && cell_ok) begin
      if (req_op_r == OP_BIT_CELL) begin
        mod_start    = (pos_inc > 17'(req_tbc_r));
        mod_dividend = pos_inc;
      end else if (req_op_r == OP_TRACK_CHG) begin
        mod_start    = (trk_clamp != track_r) && (position_r >= req_tbc_r);
        mod_dividend = {1'b0, position_r};
      end
    end
  end

  fnsl_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (req_tbc_r),
    .stat      (mod_stat),
    .remainder (mod_rem)
  );

  // Sequencer and engine next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    o_due_nxt     = o_due_r;
    o_pos_nxt     = o_pos_r;
    o_wen_nxt     = o_wen_r;
    o_wbit_nxt    = o_wbit_r;
    o_read_nxt    = o_read_r;
    o_nr_nxt      = o_nr_r;
    o_nw_nxt      = o_nw_r;
    motor_nxt     = motor_r;
    wmode_nxt     = wmode_r;
    disk_nxt      = disk_r;
    wprot_nxt     = wprot_r;
    position_nxt  = position_r;
    crem_nxt      = crem_r;
    vis_nxt       = vis_r;
    asm_nxt       = asm_r;
    hold_nxt      = hold_r;
    olatch_nxt    = olatch_r;
    track_nxt     = track_r;
    rd_cnt_nxt    = rd_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          o_due_nxt     = '0;
          o_pos_nxt     = position_r;
          o_wen_nxt     = 1'b0;
          o_wbit_nxt    = 1'b0;
          o_read_nxt    = vis_r;
          o_nr_nxt      = rd_cnt_r;
          o_nw_nxt      = wr_cnt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;

          unique case (req_op_r)
            OP_CYCLES: begin
              if (motor_r) begin
                o_due_nxt = due_sat;
                crem_nxt  = crem_acc;
              end
            end

            OP_BIT_CELL: begin
              if (cell_ok) begin
                if (wmode_r) begin
                  o_wbit_nxt = olatch_r[7];
                  o_wen_nxt  = !wprot_r;
                  olatch_nxt = {olatch_r[6:0], 1'b0};
                end else begin
                  vis_nxt    = vis_rd;
                  asm_nxt    = asm_rd;
                  hold_nxt   = hold_rd;
                  o_read_nxt = vis_rd;
                end
                if (pos_inc < 17'(req_tbc_r)) begin
                  position_nxt = pos_inc[POS_W-1:0];
                end else if (pos_inc == 17'(req_tbc_r)) begin
                  position_nxt = '0;
                end else begin
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_DIV;
                end
              end
            end

            OP_LATCH_RD: begin
              if ((vis_r & NIBBLE_READY) != 8'h00) begin
                rd_cnt_nxt = rd_cnt_r + 32'd1;
                o_nr_nxt   = rd_cnt_r + 32'd1;
              end
            end

            OP_LATCH_WR: begin
              olatch_nxt = req_latch_r;
              wr_cnt_nxt = wr_cnt_r + 32'd1;
              o_nw_nxt   = wr_cnt_r + 32'd1;
            end

            OP_TRACK_CHG: begin
              if (trk_clamp != track_r) begin
                track_nxt = trk_clamp;
                if (!cell_ok) begin
                  position_nxt = '0;
                  o_pos_nxt    = '0;
                end else if (position_r >= req_tbc_r) begin
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_DIV;
                end
              end
            end

            default: begin
              // Unused codes report state unchanged.
            end
          endcase
        end
      end

      S_DIV: begin
        if (mod_stat.done) begin
          position_nxt = mod_rem;
          // Track change reports the reduced position; a bit cell keeps
          // the cell it handled.
          if (req_op_r == OP_TRACK_CHG) begin
            o_pos_nxt = mod_rem;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOTOR_ON: begin
          motor_nxt = cfg_wdata;
          crem_nxt  = '0;
        end
        CFG_WRITE_MODE:    wmode_nxt = cfg_wdata;
        CFG_DISK_PRESENT:  disk_nxt  = cfg_wdata;
        CFG_WRITE_PROTECT: wprot_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      motor_r     <= 1'b0;
      wmode_r     <= 1'b0;
      disk_r      <= 1'b0;
      wprot_r     <= 1'b0;
      position_r  <= '0;
      crem_r      <= '0;
      vis_r       <= '0;
      asm_r       <= '0;
      hold_r      <= '0;
      olatch_r    <= '0;
      track_r     <= '0;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      motor_r     <= motor_nxt;
      wmode_r     <= wmode_nxt;
      disk_r      <= disk_nxt;
      wprot_r     <= wprot_nxt;
      position_r  <= position_nxt;
      crem_r      <= crem_nxt;
      vis_r       <= vis_nxt;
      asm_r       <= asm_nxt;
      hold_r      <= hold_nxt;
      olatch_r    <= olatch_nxt;
      track_r     <= track_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
    end
  end

  // Capture the request and the result payload; no reset needed.
  always_ff @(posedge clk) begin
    o_due_r  <= o_due_nxt;
    o_pos_r  <= o_pos_nxt;
    o_wen_r  <= o_wen_nxt;
    o_wbit_r <= o_wbit_nxt;
    o_read_r <= o_read_nxt;
    o_nr_r   <= o_nr_nxt;
    o_nw_r   <= o_nw_nxt;
    if (state_r == S_IDLE && in_valid) begin
      req_op_r     <= in_operation;
      req_cycles_r <= in_cycles;
      req_bit_r    <= in_disk_bit;
      req_tbc_r    <= in_track_bit_count;
      req_track_r  <= in_requested_track;
      req_latch_r  <= in_latch_value;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bits_due        = o_due_r;
  assign out_bit_position    = o_pos_r;
  assign out_write_enable    = o_wen_r;
  assign out_write_bit       = o_wbit_r;
  assign out_read_value      = o_read_r;
  assign out_nibbles_read    = o_nr_r;
  assign out_nibbles_written = o_nw_r;

  `FNSL_ASSERT_IMPL(a_result_from_work, $rose(out_valid_r), $past(state_r) != S_IDLE)
  `FNSL_ASSERT_IMPL(a_hold_bound, 1'b1, hold_r <= HOLD_W'(HOLD_CELLS))
  `FNSL_ASSERT_IMPL(a_div_active, state_r == S_DIV, mod_stat.busy || mod_stat.done)

endmodule
